### rtl/core/apo_pkg.sv
// Shared widths, codes and result type of the argmax palette overlay block.
package apo_pkg;

   localparam int SCORE_W         = 16;
   localparam int PIXEL_INDEX_W   = 16;
   localparam int CLASS_INDEX_W   = 4;
   localparam int BYTE_W          = 8;
   localparam int PIXEL_COUNT_W   = 17;
   localparam int CHANNEL_COUNT_W = 5;
   localparam int ALPHA_W         = 9;
   localparam int COLOR_W         = 3 * BYTE_W;

   localparam int APO_MAX_PIXELS  = 65536;
   localparam int APO_MAX_CLASSES = 16;

   localparam int PAL_ENTRIES = 16;
   localparam int PAL_IW      = $clog2(PAL_ENTRIES);

   localparam int CSR_IW = 2;
   localparam int CSR_DW = PIXEL_COUNT_W;

   localparam logic [CSR_IW-1:0] CSR_PIXEL_COUNT   = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_CHANNEL_COUNT = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_ALPHA         = 2'd2;

   localparam logic [PIXEL_COUNT_W-1:0]   PIXEL_COUNT_RST   = 17'd65536;
   localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_COUNT_RST = 5'd16;
   localparam logic [ALPHA_W-1:0]         ALPHA_RST         = 9'd128;

   localparam logic OP_SCORE   = 1'b0;
   localparam logic OP_PALETTE = 1'b1;

   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_W      = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_CNT_W      = $clog2(RSP_FIFO_DEPTH + 1);

   typedef struct packed {
      logic [PIXEL_INDEX_W-1:0] pixel_index;
      logic [CLASS_INDEX_W-1:0] class_index;
      logic [BYTE_W-1:0]        out_byte0;
      logic [BYTE_W-1:0]        out_byte1;
      logic [BYTE_W-1:0]        out_byte2;
      logic                     frame_end;
   } rsp_type;

endpackage

### rtl/core/apo_req_if.sv
// Request channel: score items and palette entry writes.
interface apo_req_if import apo_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic signed [SCORE_W-1:0] score;
   logic [BYTE_W-1:0]         img_byte0;
   logic [BYTE_W-1:0]         img_byte1;
   logic [BYTE_W-1:0]         img_byte2;
   logic [PAL_IW-1:0]         entry_index;
   logic [BYTE_W-1:0]         pal_comp0;
   logic [BYTE_W-1:0]         pal_comp1;
   logic [BYTE_W-1:0]         pal_comp2;

   modport source (output valid, op, score, img_byte0, img_byte1, img_byte2, entry_index,
                   pal_comp0, pal_comp1, pal_comp2, input ready);
   modport sink (input valid, op, score, img_byte0, img_byte1, img_byte2, entry_index,
                 pal_comp0, pal_comp1, pal_comp2, output ready);
endinterface

### rtl/core/apo_rsp_if.sv
// Response channel: finished pixels with class and overlay colour.
interface apo_rsp_if import apo_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [PIXEL_INDEX_W-1:0] pixel_index;
   logic [CLASS_INDEX_W-1:0] class_index;
   logic [BYTE_W-1:0]        out_byte0;
   logic [BYTE_W-1:0]        out_byte1;
   logic [BYTE_W-1:0]        out_byte2;
   logic                     frame_end;

   modport source (output valid, pixel_index, class_index, out_byte0, out_byte1, out_byte2,
                   frame_end, input ready);
   modport sink (input valid, pixel_index, class_index, out_byte0, out_byte1, out_byte2,
                 frame_end, output ready);
endinterface

### rtl/core/apo_score_mem.sv
// Per-pixel best score and class memory with write-to-read bypass.
module apo_score_mem #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16,
   parameter int DW    = 20
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_q_ff;
   logic [AW-1:0] rd_addr_ff;
   logic          byp_vld_ff;
   logic [AW-1:0] byp_addr_ff;
   logic [DW-1:0] byp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff    <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // Hold the write made on the same edge as the read; the array returns old data then.
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_vld_ff <= 1'b0;
      end else begin
         byp_vld_ff <= wr_en;
      end
      byp_addr_ff <= wr_addr;
      byp_data_ff <= wr_data;
   end

   assign rd_data = (byp_vld_ff && (byp_addr_ff == rd_addr_ff)) ? byp_data_ff : rd_q_ff;

endmodule

### rtl/core/apo_palette.sv
// Sixteen-entry colour palette, cleared by reset.
module apo_palette import apo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [PAL_IW-1:0]  wr_index,
   input  logic [COLOR_W-1:0] wr_color,
   input  logic [PAL_IW-1:0]  rd_index,
   output logic [COLOR_W-1:0] rd_color
);

   logic [COLOR_W-1:0] entry_ff [PAL_ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAL_ENTRIES; i++) begin
            entry_ff[i] <= '0;
         end
      end else if (wr_en) begin
         entry_ff[wr_index] <= wr_color;
      end
   end

   assign rd_color = entry_ff[rd_index];

endmodule

### rtl/core/apo_rsp_fifo.sv
// Output buffer for finished pixels, decoupling the pipeline from the sink.
module apo_rsp_fifo import apo_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsp_type              push_data,
   input  logic                 pop_ready,
   output logic                 not_empty,
   output rsp_type              head,
   output logic [RSP_CNT_W-1:0] count
);

   rsp_type                entry_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff;
   logic [RSP_PTR_W-1:0]   wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff;
   logic [RSP_PTR_W-1:0]   rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff;
   logic [RSP_CNT_W-1:0]   count_in;
   logic                   pop;

   assign not_empty = (count_ff != '0);
   assign pop       = not_empty && pop_ready;
   assign head      = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/argmax_palette_overlay_core.sv
// Per-pixel argmax over planar class scores with a palette colour blended over the image.
// Takes one transaction per clock cycle while ready is high, score or palette write
// alike. A score transaction reads its pixel's best score and class from the on-chip
// memory on the accepting edge, compares and writes back in the following cycle, and on
// the last channel plane blends the palette colour with the image in the next cycle and
// pushes the finished pixel into the response buffer. The single read and single write
// port of that memory set the rate at one transaction a cycle; a pixel met again by the
// very next transaction (a one-pixel plane) is served from a write bypass. A four-entry
// response buffer absorbs sink stalls: ready falls once the buffered results plus those
// still in the pipeline reach four. The score memory needs no clearing pass: channel
// zero always writes an entry before any later plane reads it. Any write to a listed
// register restarts the frame at pixel zero, channel zero.
module argmax_palette_overlay_core import apo_pkg::*; #(
   parameter int MAX_PIXELS  = APO_MAX_PIXELS,
   parameter int MAX_CLASSES = APO_MAX_CLASSES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   apo_req_if.sink           req_chan,
   apo_rsp_if.source         rsp_chan
);

   localparam int PW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CW  = $clog2(MAX_CLASSES);
   localparam int NPW = (PW + 1 > PIXEL_COUNT_W) ? PW + 1 : PIXEL_COUNT_W;
   localparam int NCW = (CW + 1 > CHANNEL_COUNT_W) ? CW + 1 : CHANNEL_COUNT_W;
   localparam int EW  = SCORE_W + CW;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

   function automatic logic [BYTE_W-1:0] blend_byte(input logic [BYTE_W-1:0]  pal,
                                                    input logic [BYTE_W-1:0]  img,
                                                    input logic [ALPHA_W-1:0] a);
      logic [ALPHA_W+BYTE_W-1:0] pal_part;
      logic [ALPHA_W+BYTE_W-1:0] img_part;
      logic [ALPHA_W+BYTE_W-1:0] sum;
      pal_part = (ALPHA_W + BYTE_W)'(ALPHA_ONE - a) * (ALPHA_W + BYTE_W)'(pal);
      img_part = (ALPHA_W + BYTE_W)'(a) * (ALPHA_W + BYTE_W)'(img);
      sum      = pal_part + img_part;
      return sum[2*BYTE_W-1:BYTE_W];
   endfunction

   // configuration
   logic [PIXEL_COUNT_W-1:0]   pix_count_ff;
   logic [PIXEL_COUNT_W-1:0]   pix_count_in;
   logic [CHANNEL_COUNT_W-1:0] chan_count_ff;
   logic [CHANNEL_COUNT_W-1:0] chan_count_in;
   logic [ALPHA_W-1:0]         alpha_ff;
   logic [ALPHA_W-1:0]         alpha_in;
   logic                       csr_listed;
   logic [NPW-1:0]             np_ext;
   logic [NPW-1:0]             np;
   logic [NCW-1:0]             nc_ext;
   logic [NCW-1:0]             nc;
   logic [ALPHA_W-1:0]         alpha_eff;

   // frame position
   logic [PW-1:0] pix_ff;
   logic [PW-1:0] pix_in;
   logic [CW-1:0] chan_ff;
   logic [CW-1:0] chan_in;
   logic          pix_last;
   logic          chan_last;

   // handshake
   logic                 accept;
   logic                 score_acc;
   logic                 pal_acc;
   logic [RSP_CNT_W:0]   occupancy;
   logic [RSP_CNT_W-1:0] fifo_count;
   logic                 fifo_not_empty;
   rsp_type              fifo_head;
   rsp_type              ov_rsp;

   // read stage
   logic                      rd_vld_ff;
   logic                      rd_last_ff;
   logic [PW-1:0]             rd_pix_ff;
   logic [CW-1:0]             rd_chan_ff;
   logic signed [SCORE_W-1:0] rd_score_ff;
   logic [COLOR_W-1:0]        rd_img_ff;
   logic                      rd_frame_end_ff;

   // compare and write-back
   logic [EW-1:0]             mem_rd_data;
   logic signed [SCORE_W-1:0] cur_score;
   logic [CW-1:0]             cur_class;
   logic                      take;
   logic [CW-1:0]             win_class;
   logic                      mem_wr_en;
   logic [COLOR_W-1:0]        pal_color;

   // overlay stage
   logic                     ov_vld_ff;
   logic [PIXEL_INDEX_W-1:0] ov_pix_ff;
   logic [CLASS_INDEX_W-1:0] ov_class_ff;
   logic [COLOR_W-1:0]       ov_color_ff;
   logic [COLOR_W-1:0]       ov_img_ff;
   logic                     ov_frame_end_ff;

   // effective register values
   always_comb begin
      np_ext = NPW'(pix_count_ff);
      if (pix_count_ff == '0) begin
         np = NPW'(1);
      end else if (np_ext > NPW'(MAX_PIXELS)) begin
         np = NPW'(MAX_PIXELS);
      end else begin
         np = np_ext;
      end
      nc_ext = NCW'(chan_count_ff);
      if (chan_count_ff == '0) begin
         nc = NCW'(1);
      end else if (nc_ext > NCW'(MAX_CLASSES)) begin
         nc = NCW'(MAX_CLASSES);
      end else begin
         nc = nc_ext;
      end
      alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   end

   assign csr_listed = csr_wr_en && ((csr_index == CSR_PIXEL_COUNT) ||
                                     (csr_index == CSR_CHANNEL_COUNT) ||
                                     (csr_index == CSR_ALPHA));

   always_comb begin
      pix_count_in  = pix_count_ff;
      chan_count_in = chan_count_ff;
      alpha_in      = alpha_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PIXEL_COUNT:   pix_count_in  = csr_wdata[PIXEL_COUNT_W-1:0];
            CSR_CHANNEL_COUNT: chan_count_in = csr_wdata[CHANNEL_COUNT_W-1:0];
            CSR_ALPHA:         alpha_in      = csr_wdata[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: keep room in the buffer for everything still in flight
   assign accept    = req_chan.valid && req_chan.ready;
   assign score_acc = accept && (req_chan.op == OP_SCORE);
   assign pal_acc   = accept && (req_chan.op == OP_PALETTE);
   assign occupancy = (RSP_CNT_W + 1)'(fifo_count) + (RSP_CNT_W + 1)'(rd_vld_ff && rd_last_ff)
                    + (RSP_CNT_W + 1)'(ov_vld_ff);
   assign req_chan.ready = (occupancy < (RSP_CNT_W + 1)'(RSP_FIFO_DEPTH));

   // frame position
   assign pix_last  = ((NPW'(pix_ff) + NPW'(1)) == np);
   assign chan_last = ((NCW'(chan_ff) + NCW'(1)) == nc);

   always_comb begin
      pix_in  = pix_ff;
      chan_in = chan_ff;
      if (csr_listed) begin
         pix_in  = '0;
         chan_in = '0;
      end else if (score_acc) begin
         if (pix_last) begin
            pix_in  = '0;
            chan_in = chan_last ? '0 : chan_ff + CW'(1);
         end else begin
            pix_in = pix_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_count_ff  <= PIXEL_COUNT_RST;
         chan_count_ff <= CHANNEL_COUNT_RST;
         alpha_ff      <= ALPHA_RST;
         pix_ff        <= '0;
         chan_ff       <= '0;
      end else begin
         pix_count_ff  <= pix_count_in;
         chan_count_ff <= chan_count_in;
         alpha_ff      <= alpha_in;
         pix_ff        <= pix_in;
         chan_ff       <= chan_in;
      end
   end

   // read stage: memory lookup issued on the accepting edge
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         rd_last_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= score_acc;
         rd_last_ff <= chan_last;
      end
      rd_pix_ff       <= pix_ff;
      rd_chan_ff      <= chan_ff;
      rd_score_ff     <= req_chan.score;
      rd_img_ff       <= {req_chan.img_byte2, req_chan.img_byte1, req_chan.img_byte0};
      rd_frame_end_ff <= pix_last;
   end

   apo_score_mem #(
      .DEPTH (MAX_PIXELS),
      .AW    (PW),
      .DW    (EW)
   ) u_score_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (score_acc),
      .rd_addr (pix_ff),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (rd_pix_ff),
      .wr_data ({rd_score_ff, rd_chan_ff})
   );

   // compare: channel zero seeds the entry, later planes replace only on a strictly higher score
   assign cur_score = mem_rd_data[EW-1:CW];
   assign cur_class = mem_rd_data[CW-1:0];
   assign take      = (rd_chan_ff == '0) || (rd_score_ff > cur_score);
   assign win_class = take ? rd_chan_ff : cur_class;
   assign mem_wr_en = rd_vld_ff && take;

   apo_palette u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (pal_acc),
      .wr_index (req_chan.entry_index),
      .wr_color ({req_chan.pal_comp2, req_chan.pal_comp1, req_chan.pal_comp0}),
      .rd_index (PAL_IW'(win_class)),
      .rd_color (pal_color)
   );

   // overlay stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_vld_ff <= 1'b0;
      end else begin
         ov_vld_ff <= rd_vld_ff && rd_last_ff;
      end
      ov_pix_ff       <= PIXEL_INDEX_W'(rd_pix_ff);
      ov_class_ff     <= CLASS_INDEX_W'(win_class);
      ov_color_ff     <= pal_color;
      ov_img_ff       <= rd_img_ff;
      ov_frame_end_ff <= rd_frame_end_ff;
   end

   always_comb begin
      ov_rsp.pixel_index = ov_pix_ff;
      ov_rsp.class_index = ov_class_ff;
      ov_rsp.out_byte0   = blend_byte(ov_color_ff[3*BYTE_W-1:2*BYTE_W],
                                      ov_img_ff[3*BYTE_W-1:2*BYTE_W], alpha_eff);
      ov_rsp.out_byte1   = blend_byte(ov_color_ff[2*BYTE_W-1:BYTE_W],
                                      ov_img_ff[2*BYTE_W-1:BYTE_W], alpha_eff);
      ov_rsp.out_byte2   = blend_byte(ov_color_ff[BYTE_W-1:0], ov_img_ff[BYTE_W-1:0],
                                      alpha_eff);
      ov_rsp.frame_end   = ov_frame_end_ff;
   end

   apo_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (ov_vld_ff),
      .push_data (ov_rsp),
      .pop_ready (rsp_chan.ready),
      .not_empty (fifo_not_empty),
      .head      (fifo_head),
      .count     (fifo_count)
   );

   assign rsp_chan.valid       = fifo_not_empty;
   assign rsp_chan.pixel_index = fifo_head.pixel_index;
   assign rsp_chan.class_index = fifo_head.class_index;
   assign rsp_chan.out_byte0   = fifo_head.out_byte0;
   assign rsp_chan.out_byte1   = fifo_head.out_byte1;
   assign rsp_chan.out_byte2   = fifo_head.out_byte2;
   assign rsp_chan.frame_end   = fifo_head.frame_end;

endmodule

### sim/testbench.sv
// Self-checking testbench for the argmax palette overlay core.
`timescale 1ns / 100ps

module testbench;
   import apo_pkg::*;

   typedef struct packed {
      logic                      op;
      logic signed [SCORE_W-1:0] score;
      logic [BYTE_W-1:0]         img_byte0;
      logic [BYTE_W-1:0]         img_byte1;
      logic [BYTE_W-1:0]         img_byte2;
      logic [PAL_IW-1:0]         entry_index;
      logic [BYTE_W-1:0]         pal_comp0;
      logic [BYTE_W-1:0]         pal_comp1;
      logic [BYTE_W-1:0]         pal_comp2;
   } pixel_req_type;

   // Tracks per-pixel argmax state and the palette, and holds the pixels still owed.
   class overlay_scoreboard;
      logic signed [SCORE_W-1:0] best_score [APO_MAX_PIXELS];
      logic [CLASS_INDEX_W-1:0]  best_class [APO_MAX_PIXELS];
      logic [COLOR_W-1:0]        palette [PAL_ENTRIES];
      int unsigned               pixel_pos;
      int unsigned               plane;
      int unsigned               pixel_count;
      int unsigned               channel_count;
      int unsigned               alpha;
      rsp_type                   awaited [$];
      int unsigned               failures;

      function new();
         foreach (palette[i]) palette[i] = '0;
         pixel_pos = 0;
         plane = 0;
         pixel_count = PIXEL_COUNT_RST;
         channel_count = CHANNEL_COUNT_RST;
         alpha = ALPHA_RST;
         failures = 0;
      endfunction

      function int unsigned eff_pixels();
         if (pixel_count == 0) return 1;
         if (pixel_count > APO_MAX_PIXELS) return APO_MAX_PIXELS;
         return pixel_count;
      endfunction

      function int unsigned eff_channels();
         if (channel_count == 0) return 1;
         if (channel_count > APO_MAX_CLASSES) return APO_MAX_CLASSES;
         return channel_count;
      endfunction

      function void set_register(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] value);
         case (idx)
            CSR_PIXEL_COUNT:   pixel_count = value[PIXEL_COUNT_W-1:0];
            CSR_CHANNEL_COUNT: channel_count = value[CHANNEL_COUNT_W-1:0];
            CSR_ALPHA:         alpha = value[ALPHA_W-1:0];
            default:           return;
         endcase
         // any write to a listed register restarts the frame
         pixel_pos = 0;
         plane = 0;
      endfunction

      function logic [BYTE_W-1:0] mix(logic [BYTE_W-1:0] pal, logic [BYTE_W-1:0] img,
                                      int unsigned a);
         int unsigned sum;
         sum = (256 - a) * pal + a * img;
         return BYTE_W'(sum >> 8);
      endfunction

      function void note_request(pixel_req_type it);
         int unsigned              np;
         int unsigned              nc;
         int unsigned              p;
         int unsigned              c;
         int unsigned              a;
         logic [CLASS_INDEX_W-1:0] cls;
         logic [COLOR_W-1:0]       color;
         rsp_type                  exp_px;
         if (it.op == OP_PALETTE) begin
            palette[it.entry_index] = {it.pal_comp2, it.pal_comp1, it.pal_comp0};
            return;
         end
         np = eff_pixels();
         nc = eff_channels();
         p = (pixel_pos >= np) ? 0 : pixel_pos;
         c = (plane >= nc) ? 0 : plane;
         if (c == 0 || it.score > best_score[p]) begin
            best_score[p] = it.score;
            best_class[p] = CLASS_INDEX_W'(c);
         end
         if (c == nc - 1) begin
            a = (alpha > 256) ? 256 : alpha;
            cls = best_class[p];
            color = palette[cls];
            exp_px.pixel_index = PIXEL_INDEX_W'(p);
            exp_px.class_index = cls;
            exp_px.out_byte0 = mix(color[23:16], it.img_byte2, a);
            exp_px.out_byte1 = mix(color[15:8], it.img_byte1, a);
            exp_px.out_byte2 = mix(color[7:0], it.img_byte0, a);
            exp_px.frame_end = (p == np - 1);
            awaited.push_back(exp_px);
         end
         p++;
         if (p >= np) begin
            p = 0;
            c++;
            if (c >= nc) c = 0;
         end
         pixel_pos = p;
         plane = c;
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] seen);
         if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, seen);
            failures++;
         end
      endfunction

      function void check_response(rsp_type seen);
         rsp_type want;
         if (awaited.size() == 0) begin
            $display("%0t: pixel %0d class %0d with nothing expected, expected none, got %p",
                     $time, seen.pixel_index, seen.class_index, seen);
            failures++;
            return;
         end
         want = awaited.pop_front();
         compare("pixel_index", want.pixel_index, seen.pixel_index);
         compare("class_index", want.class_index, seen.class_index);
         compare("out_byte0", want.out_byte0, seen.out_byte0);
         compare("out_byte1", want.out_byte1, seen.out_byte1);
         compare("out_byte2", want.out_byte2, seen.out_byte2);
         compare("frame_end", want.frame_end, seen.frame_end);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_wdata;
   int unsigned       req_idle_pct = 0;
   int unsigned       rsp_stall_pct = 0;

   overlay_scoreboard board = new();

   apo_req_if req_bus ();
   apo_rsp_if rsp_bus ();

   argmax_palette_overlay_core uut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   always #1 clock = ~clock;

   function automatic pixel_req_type make_score(logic [SCORE_W-1:0] s,
                                                logic [COLOR_W-1:0] img);
      pixel_req_type it;
      it.op = OP_SCORE;
      it.score = s;
      {it.img_byte2, it.img_byte1, it.img_byte0} = img;
      it.entry_index = PAL_IW'($urandom);
      {it.pal_comp2, it.pal_comp1, it.pal_comp0} = COLOR_W'($urandom);
      return it;
   endfunction

   function automatic pixel_req_type make_palette(logic [PAL_IW-1:0] idx,
                                                  logic [COLOR_W-1:0] color);
      pixel_req_type it;
      it.op = OP_PALETTE;
      it.score = SCORE_W'($urandom);
      {it.img_byte2, it.img_byte1, it.img_byte0} = COLOR_W'($urandom);
      it.entry_index = idx;
      {it.pal_comp2, it.pal_comp1, it.pal_comp0} = color;
      return it;
   endfunction

   // lean towards the extremes and towards small values that tie
   function automatic logic [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2, 3:    return SCORE_W'($urandom_range(0, 2)) - 16'd1;
         default: return SCORE_W'($urandom);
      endcase
   endfunction

   task automatic set_idle(int unsigned mode);
      case (mode)
         0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin req_idle_pct = 58; rsp_stall_pct = 0;  end
         2: begin req_idle_pct = 0;  rsp_stall_pct = 58; end
         default: begin req_idle_pct = 8; rsp_stall_pct = 8; end
      endcase
   endtask

   task automatic send_item(pixel_req_type it);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= it.op;
      req_bus.score <= it.score;
      req_bus.img_byte0 <= it.img_byte0;
      req_bus.img_byte1 <= it.img_byte1;
      req_bus.img_byte2 <= it.img_byte2;
      req_bus.entry_index <= it.entry_index;
      req_bus.pal_comp0 <= it.pal_comp0;
      req_bus.pal_comp1 <= it.pal_comp1;
      req_bus.pal_comp2 <= it.pal_comp2;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_request(it);
   endtask

   // drop valid, drain every owed pixel, then let the last score write-backs leave the pipeline
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(bit [2:0] mask, logic [CSR_DW-1:0] pc, logic [CSR_DW-1:0] cc,
                                 logic [CSR_DW-1:0] al);
      logic [CSR_IW-1:0] regs [3];
      logic [CSR_DW-1:0] value [3];
      regs = '{CSR_PIXEL_COUNT, CSR_CHANNEL_COUNT, CSR_ALPHA};
      value = '{pc, cc, al};
      settle();
      for (int i = 0; i < 3; i++) begin
         if (mask[i]) begin
            csr_wr_en <= 1'b1;
            csr_index <= regs[i];
            csr_wdata <= value[i];
            @(posedge clock);
            board.set_register(regs[i], value[i]);
         end
      end
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      rsp_type seen_px;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            seen_px = {rsp_bus.pixel_index, rsp_bus.class_index, rsp_bus.out_byte0,
                       rsp_bus.out_byte1, rsp_bus.out_byte2, rsp_bus.frame_end};
            board.check_response(seen_px);
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   initial begin
      #1000000;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      int unsigned        random_items;
      int unsigned        phase_no;
      int unsigned        frame;
      int unsigned        n;
      bit                 heavy;
      logic [CSR_DW-1:0]  pc;
      logic [CSR_DW-1:0]  cc;
      logic [CSR_DW-1:0]  al;
      req_bus.valid <= 1'b0;
      req_bus.op <= OP_SCORE;
      req_bus.score <= '0;
      req_bus.img_byte0 <= '0;
      req_bus.img_byte1 <= '0;
      req_bus.img_byte2 <= '0;
      req_bus.entry_index <= '0;
      req_bus.pal_comp0 <= '0;
      req_bus.pal_comp1 <= '0;
      req_bus.pal_comp2 <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_PIXEL_COUNT;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // two pixels, three channels, alpha left at its reset value
      set_idle(0);
      write_settings(3'b011, 17'd2, 17'd3, 17'd0);
      send_item(make_palette(4'd0, 24'hFFFFFF));
      send_item(make_palette(4'd2, 24'h00FF00));
      send_item(make_palette(4'd15, 24'h123456));
      send_item(make_palette(4'd1, 24'h0000FF));
      send_item(make_score(16'h8000, 24'h000000));
      send_item(make_score(16'h7FFF, 24'hFFFFFF));
      send_item(make_score(16'h8000, 24'hFF00FF));
      send_item(make_score(16'h7FFF, 24'h00FF00));
      send_item(make_score(16'h8001, 24'hFFFFFF));
      send_item(make_score(16'h8000, 24'h00FF00));

      // zero counts fall back to one: every score is a finished pixel of class zero
      set_idle(1);
      write_settings(3'b111, 17'd0, 17'd0, 17'd0);
      send_item(make_score(16'h0000, 24'hFFFFFF));
      send_item(make_palette(4'd0, 24'h000000));
      send_item(make_score(16'h7FFF, 24'h80FF01));

      // the oversized pixel count and alpha saturate
      set_idle(2);
      write_settings(3'b111, 17'h1FFFF, 17'd1, 17'd511);
      repeat (4) send_item(make_score(pick_score(), COLOR_W'($urandom)));

      // one-pixel plane: each pixel is revisited by the very next transaction
      set_idle(3);
      write_settings(3'b111, 17'd1, 17'd2, 17'd256);
      send_item(make_score(16'hFFFB, 24'h0102FE));
      send_item(make_score(16'hFFFD, 24'hFE0201));
      send_item(make_score(16'h0007, 24'h55AA55));
      send_item(make_score(16'h0007, 24'hAA55AA));

      random_items = 0;
      phase_no = 0;
      while (random_items < 800) begin
         phase_no++;
         set_idle(phase_no % 4);
         heavy = ($urandom_range(0, 9) == 0);
         if (heavy) begin
            case ($urandom_range(0, 2))
               0:       pc = 17'd65536;
               1:       pc = 17'h1FFFF;
               default: pc = CSR_DW'($urandom_range(65537, 131071));
            endcase
            cc = CSR_DW'($urandom_range(0, 2));
         end else begin
            pc = ($urandom_range(0, 7) == 0) ? 17'd0 : CSR_DW'($urandom_range(1, 6));
            if ($urandom_range(0, 3) == 0) cc = CSR_DW'($urandom_range(0, 31));
            else cc = CSR_DW'($urandom_range(1, 4));
         end
         case ($urandom_range(0, 7))
            0:       al = 17'd0;
            1:       al = 17'd256;
            2:       al = 17'd511;
            3:       al = CSR_DW'($urandom_range(257, 511));
            default: al = CSR_DW'($urandom_range(0, 256));
         endcase
         write_settings(3'b111, pc, cc, al);
         frame = board.eff_pixels() * board.eff_channels();
         if (heavy) n = $urandom_range(10, 40);
         else n = frame * $urandom_range(1, 3) + $urandom_range(0, 2);
         if (n > 150) n = 150;
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_item(make_palette(PAL_IW'($urandom), COLOR_W'($urandom)));
               random_items++;
            end
            send_item(make_score(pick_score(), COLOR_W'($urandom)));
            random_items++;
         end
      end

      settle();
      repeat (4) @(posedge clock);
      if (board.failures == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
